### hdl/depth_pixel_to_point_unit_macros.svh
// assertion macros for the depth pixel to point unit
// expects clk_i and rst_ni in the scope of each use
`ifndef DEPTH_PIXEL_TO_POINT_UNIT_MACROS_SVH
`define DEPTH_PIXEL_TO_POINT_UNIT_MACROS_SVH

// same-cycle implication
`define DPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dpp_pkg.sv
// shared types and constants for the depth pixel to point unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

  // per-stage advance enables, shared by the top level and the axis datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  localparam int unsigned IndexW = 10;
  localparam int unsigned CentreW = 14;
  localparam int unsigned InvW = 24;
  localparam int unsigned ZW = 23;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 24;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_INV_FOCAL_X = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_INV_FOCAL_Y = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTRE_X = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTRE_Y = 4'd3;

  // floor(m / 125) = (m * RECIP_125) >> RECIP_SHIFT, exact for m < 2^29
  localparam logic [29:0] RECIP_125 = 30'd549755814;
  localparam int unsigned RECIP_SHIFT = 36;
  // rounding term for depth * 65536 / 1000 after the divide by 8
  localparam logic [28:0] Z_ROUND = 29'd62;

  localparam logic [7:0] FULL_ALPHA = 8'hFF;

endpackage

`default_nettype wire

### hdl/dpp_axis.sv
// one projection axis: (index*16 - centre) * inv_focal * z, rounded and saturated
// four register stages driven by stage enables from dpp_pkg::stage_en_t
`timescale 1ns / 1ps
`default_nettype none

module dpp_axis (
  input  wire                          clk_i,
  input  dpp_pkg::stage_en_t           en_i,
  input  wire  [dpp_pkg::IndexW-1:0]   index_i,
  input  wire  [dpp_pkg::CentreW-1:0]  centre_i,
  input  wire  [dpp_pkg::InvW-1:0]     inv_focal_i,
  input  wire  [dpp_pkg::ZW-1:0]       z_i,
  output logic [dpp_pkg::CoordW-1:0]   coord_o
);
  import dpp_pkg::*;

  logic [CentreW-1:0] pos;
  logic               neg;
  logic [CentreW-1:0] mag;

  logic [37:0] prod_q;
  logic        neg1_q;
  logic [41:0] part_lo_q, part_hi_q;
  logic        neg2_q;
  logic [61:0] sum;
  logic [33:0] res_q;
  logic        neg3_q;
  logic [CoordW-1:0] coord_d, coord_q;

  // stage 1: signed offset magnitude times inverse focal length
  always_comb begin
    pos = {index_i, 4'b0000};
    neg = pos < centre_i;
    mag = neg ? (centre_i - pos) : (pos - centre_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_q <= 38'(mag) * 38'(inv_focal_i);
      neg1_q <= neg;
    end
  end

  // stage 2: two partial products against z
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      part_lo_q <= 42'(prod_q[18:0]) * 42'(z_i);
      part_hi_q <= 42'(prod_q[37:19]) * 42'(z_i);
      neg2_q    <= neg1_q;
    end
  end

  // stage 3: combine, round half away from zero on the magnitude
  assign sum = (62'(part_hi_q) << 19) + 62'(part_lo_q) + (62'(1) << 27);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_q  <= sum[61:28];
      neg3_q <= neg2_q;
    end
  end

  // stage 4: saturate and apply sign
  always_comb begin
    if (!neg3_q) begin
      coord_d = (res_q > 34'h07FFFFFFF) ? 32'h7FFFFFFF : res_q[31:0];
    end else begin
      coord_d = (res_q >= 34'h080000000) ? 32'h80000000 : (32'd0 - res_q[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

### hdl/depth_pixel_to_point_unit.sv
// Depth pixel to point unit: back-projects one depth pixel per clock through a pinhole
// model into a Q16.16 point with colour. Throughput is one beat per cycle while the sink
// accepts; each beat passes the four register stages of the multiply chain (offset times
// 1/f, two partial products against z, round, saturate). z comes from a reciprocal
// multiply by 1/125 in the first stage. A full output register lets new beats enter while
// a result waits; bubbles are squeezed out under backpressure. The user must write
// registers via the cfg channel only while the unit is idle; the unit does not enforce it.
// depends on dpp_pkg, dpp_axis and depth_pixel_to_point_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "depth_pixel_to_point_unit_macros.svh"

module depth_pixel_to_point_unit #(
  parameter int unsigned COLUMN_LIMIT = 1024,
  parameter int unsigned ROW_LIMIT = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [dpp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [dpp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire                            s_tvalid_i,
  output logic                           s_tready_o,
  // pixel_column, pixel_row, depth_raw, blue_in, green_in, red_in, 4 zero bits
  input  wire  [63:0]                    s_tdata_i,
  output logic                           m_tvalid_o,
  input  wire                            m_tready_i,
  // point_x, point_y, point_z, point_valid, red_out, green_out, blue_out, alpha_out
  output logic [119:0]                   m_tdata_o
);
  import dpp_pkg::*;

  localparam int unsigned LimW = 13;

  stage_en_t en;

  logic [InvW-1:0]    inv_x_q, inv_y_q;
  logic [CentreW-1:0] ctr_x_q, ctr_y_q;

  logic [IndexW-1:0] col, row;
  logic [15:0]       depth;
  logic [23:0]       colour;
  logic              bad;
  logic [28:0]       depth_m;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [58:0] zmul_q;
  logic        ok1_q, ok2_q, ok3_q, ok4_q;
  logic [23:0] col1_q, col2_q, col3_q, col4_q;
  logic [ZW-1:0] z2_q, z3_q, z4_q;
  logic [ZW-1:0] z2_d;

  logic [CoordW-1:0] px, py;
  logic [CoordW-1:0] px_o, py_o;
  logic [ZW-1:0]     pz_o;
  logic [7:0]        red_o, green_o, blue_o, alpha_o;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= '0;
      inv_y_q <= '0;
      ctr_x_q <= '0;
      ctr_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INV_FOCAL_X: inv_x_q <= cfg_data_i;
        CFG_INV_FOCAL_Y: inv_y_q <= cfg_data_i;
        CFG_CENTRE_X:    ctr_x_q <= cfg_data_i[CentreW-1:0];
        CFG_CENTRE_Y:    ctr_y_q <= cfg_data_i[CentreW-1:0];
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when its successor is empty or moving
  assign en.s4 = !v4_q || m_tready_i;
  assign en.s3 = !v3_q || en.s4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;
  assign s_tready_o = en.s1;

  // input unpack
  assign col    = s_tdata_i[9:0];
  assign row    = s_tdata_i[19:10];
  assign depth  = s_tdata_i[35:20];
  assign colour = s_tdata_i[59:36];
  assign bad    = (depth == 16'd0) ||
                  ({3'b000, col} >= LimW'(COLUMN_LIMIT)) ||
                  ({3'b000, row} >= LimW'(ROW_LIMIT));
  // floor((depth * 65536 + 500) / 8)
  assign depth_m = {depth, 13'd0} + Z_ROUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= s_tvalid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  assign z2_d = zmul_q[RECIP_SHIFT +: ZW];

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      zmul_q <= 59'(depth_m) * 59'(RECIP_125);
      ok1_q  <= !bad;
      col1_q <= colour;
    end
    if (en.s2) begin
      z2_q   <= z2_d;
      ok2_q  <= ok1_q;
      col2_q <= col1_q;
    end
    if (en.s3) begin
      z3_q   <= z2_q;
      ok3_q  <= ok2_q;
      col3_q <= col2_q;
    end
    if (en.s4) begin
      z4_q   <= z3_q;
      ok4_q  <= ok3_q;
      col4_q <= col3_q;
    end
  end

  dpp_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en),
    .index_i     (col),
    .centre_i    (ctr_x_q),
    .inv_focal_i (inv_x_q),
    .z_i         (z2_d),
    .coord_o     (px)
  );

  dpp_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (en),
    .index_i     (row),
    .centre_i    (ctr_y_q),
    .inv_focal_i (inv_y_q),
    .z_i         (z2_d),
    .coord_o     (py)
  );

  // invalid points carry all zero fields
  assign px_o    = ok4_q ? px : '0;
  assign py_o    = ok4_q ? py : '0;
  assign pz_o    = ok4_q ? z4_q : '0;
  assign blue_o  = ok4_q ? col4_q[7:0] : 8'd0;
  assign green_o = ok4_q ? col4_q[15:8] : 8'd0;
  assign red_o   = ok4_q ? col4_q[23:16] : 8'd0;
  assign alpha_o = ok4_q ? FULL_ALPHA : 8'd0;

  assign m_tvalid_o = v4_q;
  assign m_tdata_o  = {alpha_o, blue_o, green_o, red_o, ok4_q, pz_o, py_o, px_o};

  `DPP_ASSERT_NOW(a_ready_follows_sink, m_tready_i, s_tready_o, "input stalled with sink ready")
  `DPP_ASSERT_NOW(a_valid_alpha, m_tvalid_o && m_tdata_o[87], m_tdata_o[119:112] == FULL_ALPHA, "valid point without full alpha")
  `DPP_ASSERT_NOW(a_valid_z, m_tvalid_o && m_tdata_o[87], m_tdata_o[86:64] != '0, "valid point with zero depth")
  `DPP_ASSERT_NOW(a_invalid_zero, m_tvalid_o && !m_tdata_o[87], m_tdata_o == '0, "invalid point with nonzero fields")
  `DPP_ASSERT_NEXT(a_fill_on_stall, s_tvalid_i && s_tready_o && !m_tready_i && !m_tvalid_o, v1_q, "accepted beat lost under stall")

endmodule

`default_nettype wire
